[src/sock_pkg.sv]
// Shared constants, types and helpers for the steer/omni chassis kinematics.
// Holds phase formats, the CORDIC angle table and the configuration index codes.
// No dependencies.
`timescale 1ns / 1ps

package sock_pkg;

    localparam int COUNTS_PER_TURN = 8192;
    localparam int CNT_W           = $clog2(COUNTS_PER_TURN);
    localparam int PHASE_SHIFT     = 32 - CNT_W;
    localparam int CORDIC_STEPS    = 16;
    localparam int MAX_STEPS       = 24;

    localparam int DW    = 32;   // CORDIC datapath width
    localparam int ZW    = 33;   // CORDIC angle accumulator width
    localparam int LEV_W = 28;   // lever term width
    localparam int SPD_W = 16;
    localparam int ARM_W = 12;
    localparam int GAIN_W = 16;

    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
    localparam logic [29:0] KINV_Q30           = 30'd652032874;

    localparam logic [31:0] ATAN_TAB [0:MAX_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Register index codes
    localparam logic [2:0] CFG_DIAG_ARM        = 3'd0;
    localparam logic [2:0] CFG_ARM_X           = 3'd1;
    localparam logic [2:0] CFG_ARM_Y           = 3'd2;
    localparam logic [2:0] CFG_FRONT_LEFT_DIR  = 3'd3;
    localparam logic [2:0] CFG_FRONT_RIGHT_DIR = 3'd4;
    localparam logic [2:0] CFG_REAR_LEFT_ZERO  = 3'd5;
    localparam logic [2:0] CFG_REAR_RIGHT_ZERO = 3'd6;
    localparam logic [2:0] CFG_RPM_GAIN        = 3'd7;

    typedef struct packed {
        logic signed [LEV_W-1:0] diag;
        logic signed [LEV_W-1:0] lev_y;
        logic signed [LEV_W-1:0] lev_x;
        logic                    zero_cmd;
        logic [CNT_W-1:0]        lpos;
        logic [CNT_W-1:0]        rpos;
    } t_turret_meta;

    typedef struct packed {
        logic             zero_cmd;
        logic [CNT_W-1:0] pos;
    } t_rear_meta;

    function automatic logic [31:0] to_phase(input logic [CNT_W-1:0] c);
        return {c, {PHASE_SHIFT{1'b0}}};
    endfunction

endpackage

[src/steer_omni_chassis_kinematics.sv]
// Top level of the steer/omni chassis inverse kinematics.
// Depends on sock_pkg, sock_lever, sock_cordic and sock_merge.
//
// Usage:
//   Command channel: a command transfers at a rising edge with start high and
//   busy low. busy stays low, so a new command may follow every cycle.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
//   edge; write only while no command is in flight.
//   Result: o_done pulses for one cycle with the six result fields valid in
//   that cycle. The receiver cannot stall; results are never held.
// Throughput and pipeline:
//   one command per cycle. The path runs through two CORDIC pipelines in
//   series, the turret rotation, then the four wheel lanes side by side,
//   between the lever stage in front and the merge stage behind.
// Reset:
//   i_rst_n low (synchronous) clears all in-flight commands and restores the
//   register defaults.
`timescale 1ns / 1ps

module steer_omni_chassis_kinematics
    import sock_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      i_vel_x,
    input  logic signed [15:0]      i_vel_y,
    input  logic signed [15:0]      i_yaw_rate,
    input  logic [CNT_W-1:0]        i_turret_angle,
    input  logic [CNT_W-1:0]        i_rear_left_pos,
    input  logic [CNT_W-1:0]        i_rear_right_pos,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    output logic                    o_done,
    output logic [CNT_W-1:0]        o_rear_left_target,
    output logic [CNT_W-1:0]        o_rear_right_target,
    output logic signed [SPD_W-1:0] o_front_left_speed,
    output logic signed [SPD_W-1:0] o_rear_left_speed,
    output logic signed [SPD_W-1:0] o_rear_right_speed,
    output logic signed [SPD_W-1:0] o_front_right_speed
);

    localparam int DLY = 3;   // lever pipeline depth

    // ---------------- configuration registers ----------------
    logic [ARM_W-1:0]  r_diag_arm, r_arm_x, r_arm_y;
    logic [CNT_W-1:0]  r_fl_dir, r_fr_dir, r_rl_zero, r_rr_zero;
    logic [GAIN_W-1:0] r_rpm_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_arm <= ARM_W'(300);
            r_arm_x    <= ARM_W'(200);
            r_arm_y    <= ARM_W'(200);
            r_fl_dir   <= CNT_W'(1024);
            r_fr_dir   <= CNT_W'(7168);
            r_rl_zero  <= '0;
            r_rr_zero  <= '0;
            r_rpm_gain <= GAIN_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIAG_ARM:        r_diag_arm <= i_cfg_data[ARM_W-1:0];
                CFG_ARM_X:           r_arm_x    <= i_cfg_data[ARM_W-1:0];
                CFG_ARM_Y:           r_arm_y    <= i_cfg_data[ARM_W-1:0];
                CFG_FRONT_LEFT_DIR:  r_fl_dir   <= i_cfg_data[CNT_W-1:0];
                CFG_FRONT_RIGHT_DIR: r_fr_dir   <= i_cfg_data[CNT_W-1:0];
                CFG_REAR_LEFT_ZERO:  r_rl_zero  <= i_cfg_data[CNT_W-1:0];
                CFG_REAR_RIGHT_ZERO: r_rr_zero  <= i_cfg_data[CNT_W-1:0];
                CFG_RPM_GAIN:        r_rpm_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- lever terms, command held alongside ----------------
    logic                    r_d_vld [0:DLY-1];
    logic signed [15:0]      r_d_vx  [0:DLY-1];
    logic signed [15:0]      r_d_vy  [0:DLY-1];
    logic                    r_d_zero [0:DLY-1];
    logic [CNT_W-1:0]        r_d_tur [0:DLY-1];
    logic [CNT_W-1:0]        r_d_lp  [0:DLY-1];
    logic [CNT_W-1:0]        r_d_rp  [0:DLY-1];
    logic signed [LEV_W-1:0] lev_diag, lev_y, lev_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DLY; j++) begin
                r_d_vld[j] <= 1'b0;
            end
        end else begin
            r_d_vld[0] <= start && !busy;
            for (int j = 1; j < DLY; j++) begin
                r_d_vld[j] <= r_d_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_vx[0]   <= i_vel_x;
        r_d_vy[0]   <= i_vel_y;
        r_d_zero[0] <= (i_vel_x == 0) && (i_vel_y == 0) && (i_yaw_rate == 0);
        r_d_tur[0]  <= i_turret_angle;
        r_d_lp[0]   <= i_rear_left_pos;
        r_d_rp[0]   <= i_rear_right_pos;
        for (int j = 1; j < DLY; j++) begin
            r_d_vx[j]   <= r_d_vx[j-1];
            r_d_vy[j]   <= r_d_vy[j-1];
            r_d_zero[j] <= r_d_zero[j-1];
            r_d_tur[j]  <= r_d_tur[j-1];
            r_d_lp[j]   <= r_d_lp[j-1];
            r_d_rp[j]   <= r_d_rp[j-1];
        end
    end

    sock_lever u_lev_diag (.i_clk(i_clk), .i_wz(i_yaw_rate), .i_arm(r_diag_arm),
                           .o_lev(lev_diag));
    sock_lever u_lev_y    (.i_clk(i_clk), .i_wz(i_yaw_rate), .i_arm(r_arm_y),
                           .o_lev(lev_y));
    sock_lever u_lev_x    (.i_clk(i_clk), .i_wz(i_yaw_rate), .i_arm(r_arm_x),
                           .o_lev(lev_x));

    // ---------------- turret to chassis rotation ----------------
    t_turret_meta          tur_meta_in, tur_meta_out;
    logic                  tur_vld;
    logic signed [DW-1:0]  cx, cy;

    assign tur_meta_in = '{diag: lev_diag, lev_y: lev_y, lev_x: lev_x,
                           zero_cmd: r_d_zero[DLY-1], lpos: r_d_lp[DLY-1],
                           rpos: r_d_rp[DLY-1]};

    sock_cordic #(.STEPS(STEPS), .VECTORING(0), .PW($bits(t_turret_meta))) u_turret (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld[DLY-1]),
        .i_x     (DW'($signed({r_d_vx[DLY-1], 8'h00}))),
        .i_y     (DW'($signed({r_d_vy[DLY-1], 8'h00}))),
        .i_phase (to_phase(r_d_tur[DLY-1])),
        .i_meta  (tur_meta_in),
        .o_valid (tur_vld),
        .o_x     (cx),
        .o_y     (cy),
        .o_phase (),
        .o_meta  (tur_meta_out)
    );

    // ---------------- wheel lane inputs ----------------
    logic                 r_c_vld;
    logic signed [DW-1:0] r_c_lx, r_c_ly, r_c_rx, r_c_ry, r_c_p, r_c_q;
    t_rear_meta           r_c_lmeta;
    logic [CNT_W-1:0]     r_c_rpos;
    logic signed [DW-1:0] t_ext;

    assign t_ext = DW'(tur_meta_out.diag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= tur_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_lx    <= cy - t_ext;
        r_c_ly    <= cx - t_ext;
        r_c_rx    <= cy + t_ext;
        r_c_ry    <= cx + t_ext;
        r_c_p     <= cx - DW'(tur_meta_out.lev_y);
        r_c_q     <= cy + DW'(tur_meta_out.lev_x);
        r_c_lmeta <= '{zero_cmd: tur_meta_out.zero_cmd, pos: tur_meta_out.lpos};
        r_c_rpos  <= tur_meta_out.rpos;
    end

    // ---------------- four wheel lanes ----------------
    logic                 lane_vld;
    logic signed [DW-1:0] lmag, rmag, fl, fr;
    logic [31:0]          laz, raz;
    t_rear_meta           lmeta;
    logic [CNT_W-1:0]     rpos_d;

    sock_cordic #(.STEPS(STEPS), .VECTORING(1), .PW($bits(t_rear_meta))) u_rear_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld),
        .i_x(r_c_lx), .i_y(r_c_ly), .i_phase(32'd0), .i_meta(r_c_lmeta),
        .o_valid(lane_vld), .o_x(lmag), .o_y(), .o_phase(laz), .o_meta(lmeta)
    );

    sock_cordic #(.STEPS(STEPS), .VECTORING(1), .PW(CNT_W)) u_rear_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld),
        .i_x(r_c_rx), .i_y(r_c_ry), .i_phase(32'd0), .i_meta(r_c_rpos),
        .o_valid(), .o_x(rmag), .o_y(), .o_phase(raz), .o_meta(rpos_d)
    );

    sock_cordic #(.STEPS(STEPS), .VECTORING(0), .PW(1)) u_front_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld),
        .i_x(r_c_p), .i_y(r_c_q), .i_phase(32'd0 - to_phase(r_fl_dir)),
        .i_meta(1'b0),
        .o_valid(), .o_x(fl), .o_y(), .o_phase(), .o_meta()
    );

    sock_cordic #(.STEPS(STEPS), .VECTORING(0), .PW(1)) u_front_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld),
        .i_x(r_c_p), .i_y(r_c_q), .i_phase(32'd0 - to_phase(r_fr_dir)),
        .i_meta(1'b0),
        .o_valid(), .o_x(fr), .o_y(), .o_phase(), .o_meta()
    );

    // ---------------- merge ----------------
    sock_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lane_vld),
        .i_laz   (laz),
        .i_raz   (raz),
        .i_lmag  (lmag),
        .i_rmag  (rmag),
        .i_fl    (fl),
        .i_fr    (fr),
        .i_lmeta (lmeta),
        .i_rpos  (rpos_d),
        .i_lzero (r_rl_zero),
        .i_rzero (r_rr_zero),
        .i_gain  (r_rpm_gain),
        .o_done  (o_done),
        .o_ltgt  (o_rear_left_target),
        .o_rtgt  (o_rear_right_target),
        .o_fl    (o_front_left_speed),
        .o_rl    (o_rear_left_speed),
        .o_rr    (o_rear_right_speed),
        .o_fr    (o_front_right_speed)
    );

endmodule

[src/sock_lever.sv]
// Rotational lever term: yaw_rate * arm * 256 / 1000, truncated toward zero.
// Three-stage pipeline using a reciprocal multiply with one correction step.
// Depends on sock_pkg.
`timescale 1ns / 1ps

module sock_lever
    import sock_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [15:0]       i_wz,
    input  logic [ARM_W-1:0]         i_arm,
    output logic signed [LEV_W-1:0]  o_lev
);

    localparam int MAG_W = LEV_W;
    localparam int RSH   = 28;
    localparam int Q_W   = 27;
    localparam logic [26:0] RECIP = 27'd68719476;   // floor(2^33 / 125)

    logic signed [28:0] n_prod;
    logic [MAG_W-1:0]   n_mag;
    logic               r_neg1, r_neg2;
    logic [MAG_W-1:0]   r_mag1, r_mag2;
    logic [55:0]        n_qprod;
    logic [Q_W-1:0]     r_q0;
    logic [32:0]        n_rem;
    logic [Q_W-1:0]     n_q;
    logic signed [LEV_W-1:0] r_lev;

    assign n_prod = 29'(i_wz) * 29'($signed({1'b0, i_arm}));
    assign n_mag  = n_prod[28] ? MAG_W'(-n_prod) : MAG_W'(n_prod);

    always_ff @(posedge i_clk) begin
        r_neg1 <= n_prod[28];
        r_mag1 <= n_mag;
    end

    assign n_qprod = 56'(r_mag1) * 56'(RECIP);

    always_ff @(posedge i_clk) begin
        r_neg2 <= r_neg1;
        r_mag2 <= r_mag1;
        r_q0   <= n_qprod[RSH +: Q_W];
    end

    // Estimate is low by at most one
    assign n_rem = {r_mag2, 5'b0} - 33'(r_q0 * 27'd125);
    assign n_q   = (n_rem >= 33'd125) ? r_q0 + 1'b1 : r_q0;

    always_ff @(posedge i_clk) begin
        r_lev <= r_neg2 ? -LEV_W'(n_q) : LEV_W'(n_q);
    end

    assign o_lev = r_lev;

endmodule

[src/sock_cordic.sv]
// Pipelined CORDIC lane, one iteration per stage, rotation or vectoring mode.
// Output is gain compensated and registered. Depends on sock_pkg.
`timescale 1ns / 1ps

module sock_cordic
    import sock_pkg::*;
#(
    parameter int STEPS     = CORDIC_STEPS,
    parameter int VECTORING = 0,
    parameter int PW        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic [31:0]          i_phase,
    input  logic [PW-1:0]        i_meta,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic [31:0]          o_phase,
    output logic [PW-1:0]        o_meta
);

    localparam int MW = DW + 31;

    logic signed [DW-1:0] r_x [0:STEPS];
    logic signed [DW-1:0] r_y [0:STEPS];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic [PW-1:0]        r_meta [0:STEPS];
    logic                 r_vld  [0:STEPS];

    logic signed [DW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic [31:0]          n_p;

    // Pre-rotation into the convergence range
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_p = i_phase;
        n_z = '0;
        if (VECTORING != 0) begin
            if (i_x < 0) begin
                n_x = -i_x;
                n_y = -i_y;
                n_z = ZW'(HALF_TURN);
            end
        end else begin
            if (i_phase >= QUARTER_TURN && i_phase < THREE_QUARTER_TURN) begin
                n_x = -i_x;
                n_y = -i_y;
                n_p = i_phase + HALF_TURN;
            end
            n_z = {n_p[31], n_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        r_meta[0] <= i_meta;
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                 ccw;
        logic signed [DW-1:0] dx, dy;
        logic signed [ZW-1:0] da;

        assign ccw = (VECTORING != 0) ? !(r_y[k] > 0) : !r_z[k][ZW-1];
        assign dx  = r_y[k] >>> k;
        assign dy  = r_x[k] >>> k;
        assign da  = ZW'(ATAN_TAB[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ccw) begin
                r_x[k+1] <= r_x[k] - dx;
                r_y[k+1] <= r_y[k] + dy;
                r_z[k+1] <= r_z[k] - da;
            end else begin
                r_x[k+1] <= r_x[k] + dx;
                r_y[k+1] <= r_y[k] - dy;
                r_z[k+1] <= r_z[k] + da;
            end
            r_zero[k+1] <= r_zero[k];
            r_meta[k+1] <= r_meta[k];
        end
    end

    logic signed [MW-1:0] r_px, r_py;
    logic [31:0]          r_ang;
    logic [PW-1:0]        r_meta_o;
    logic                 r_vld_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else begin
            r_vld_o <= r_vld[STEPS];
        end
    end

    // Remove CORDIC gain, round half up
    always_ff @(posedge i_clk) begin
        r_px     <= MW'(r_x[STEPS]) * MW'($signed({1'b0, KINV_Q30}))
                    + (MW'(1) <<< 29);
        r_py     <= MW'(r_y[STEPS]) * MW'($signed({1'b0, KINV_Q30}))
                    + (MW'(1) <<< 29);
        r_ang    <= r_zero[STEPS] ? 32'd0 : r_z[STEPS][31:0];
        r_meta_o <= r_meta[STEPS];
    end

    assign o_valid = r_vld_o;
    assign o_x     = r_px[30 +: DW];
    assign o_y     = r_py[30 +: DW];
    assign o_phase = r_ang;
    assign o_meta  = r_meta_o;

endmodule

[src/sock_merge.sv]
// Merging stage: steering targets with flip decision, drive signs, rpm scaling
// and saturation. Three pipeline stages. Depends on sock_pkg.
`timescale 1ns / 1ps

module sock_merge
    import sock_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [31:0]              i_laz,
    input  logic [31:0]              i_raz,
    input  logic signed [DW-1:0]     i_lmag,
    input  logic signed [DW-1:0]     i_rmag,
    input  logic signed [DW-1:0]     i_fl,
    input  logic signed [DW-1:0]     i_fr,
    input  t_rear_meta               i_lmeta,
    input  logic [CNT_W-1:0]         i_rpos,
    input  logic [CNT_W-1:0]         i_lzero,
    input  logic [CNT_W-1:0]         i_rzero,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic                     o_done,
    output logic [CNT_W-1:0]         o_ltgt,
    output logic [CNT_W-1:0]         o_rtgt,
    output logic signed [SPD_W-1:0]  o_fl,
    output logic signed [SPD_W-1:0]  o_rl,
    output logic signed [SPD_W-1:0]  o_rr,
    output logic signed [SPD_W-1:0]  o_fr
);

    localparam int PW2 = DW + GAIN_W + 1;
    localparam int RW  = PW2 - 16;

    function automatic logic [31:0] steer_tgt(input logic [31:0] az,
                                              input logic [CNT_W-1:0] zoff,
                                              input logic [CNT_W-1:0] pos,
                                              output logic flip);
        logic [31:0] fin;
        logic [31:0] err;
        fin  = az + to_phase(zoff);
        err  = fin - to_phase(pos);
        flip = (err > QUARTER_TURN) && (err < THREE_QUARTER_TURN);
        return flip ? fin + HALF_TURN : fin;
    endfunction

    function automatic logic [CNT_W-1:0] to_counts(input logic [31:0] ph);
        logic [31:0] rnd;
        rnd = ph + (32'd1 << (PHASE_SHIFT - 1));
        return rnd[31 -: CNT_W];
    endfunction

    function automatic logic signed [SPD_W-1:0] sat16(input logic signed [RW-1:0] v);
        if (v > RW'(32767)) begin
            return 16'sh7FFF;
        end else if (v < -RW'(32768)) begin
            return 16'sh8000;
        end
        return SPD_W'(v);
    endfunction

    logic                 lflip, rflip;
    logic [31:0]          n_ltgt, n_rtgt;
    logic [31:0]          laz;
    logic signed [DW-1:0] n_spd [0:3];

    always_comb begin
        laz    = i_lmeta.zero_cmd ? 32'd0 : i_laz;
        n_ltgt = steer_tgt(laz, i_lzero, i_lmeta.pos, lflip);
        n_rtgt = steer_tgt(i_lmeta.zero_cmd ? 32'd0 : i_raz, i_rzero, i_rpos, rflip);
        n_spd[0] = i_fl;
        n_spd[1] = lflip ? i_lmag : -i_lmag;
        n_spd[2] = rflip ? -i_rmag : i_rmag;
        n_spd[3] = i_fr;
    end

    logic                  r_vld1, r_vld2, r_vld3;
    logic [CNT_W-1:0]      r_ltgt1, r_rtgt1, r_ltgt2, r_rtgt2, r_ltgt3, r_rtgt3;
    logic signed [DW-1:0]  r_spd1 [0:3];
    logic signed [PW2-1:0] r_prod [0:3];
    logic signed [SPD_W-1:0] r_out [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ltgt1 <= to_counts(n_ltgt);
        r_rtgt1 <= to_counts(n_rtgt);
        r_ltgt2 <= r_ltgt1;
        r_rtgt2 <= r_rtgt1;
        r_ltgt3 <= r_ltgt2;
        r_rtgt3 <= r_rtgt2;
        for (int j = 0; j < 4; j++) begin
            r_spd1[j] <= n_spd[j];
            r_prod[j] <= PW2'(r_spd1[j]) * PW2'($signed({1'b0, i_gain}))
                         + PW2'(32768);
            r_out[j]  <= sat16(r_prod[j][PW2-1:16]);
        end
    end

    assign o_done = r_vld3;
    assign o_ltgt = r_ltgt3;
    assign o_rtgt = r_rtgt3;
    assign o_fl   = r_out[0];
    assign o_rl   = r_out[1];
    assign o_rr   = r_out[2];
    assign o_fr   = r_out[3];

endmodule

[sim/tb_steer_omni_chassis_kinematics.sv]
// Self-checking testbench for steer_omni_chassis_kinematics.
// A bit-exact CORDIC predictor checks every result; depends on sock_pkg and the RTL.
`timescale 1ns / 1ps

module tb_steer_omni_chassis_kinematics;
    import sock_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS + 11;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic [12:0]        turret;
        logic [12:0]        lpos;
        logic [12:0]        rpos;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    typedef struct packed {
        logic [12:0]        ltgt;
        logic [12:0]        rtgt;
        logic signed [15:0] fl;
        logic signed [15:0] rl;
        logic signed [15:0] rr;
        logic signed [15:0] fr;
    } t_wheels;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_vel_x = '0, i_vel_y = '0, i_yaw_rate = '0;
    logic [12:0] i_turret_angle = '0, i_rear_left_pos = '0, i_rear_right_pos = '0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_DIAG_ARM;
    logic [15:0] i_cfg_data = '0;
    logic o_done;
    logic [12:0] o_rear_left_target, o_rear_right_target;
    logic signed [15:0] o_front_left_speed, o_rear_left_speed;
    logic signed [15:0] o_rear_right_speed, o_front_right_speed;

    steer_omni_chassis_kinematics DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow register file
    longint r_diag, r_armx, r_army, r_fldir, r_frdir, r_lzero, r_rzero, r_gain;

    t_cmd    cmd_q[$];
    t_wheels wheels_q[$];
    int      errors = 0;
    int      gap = 0;
    logic    cfg_req = 1'b0;
    logic [2:0] cfg_req_idx;
    logic [15:0] cfg_req_data;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unscale(longint v);
        return asr(v * 64'sd652032874 + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint phase_of(longint c);
        return (c << 32) / COUNTS_PER_TURN;
    endfunction

    function automatic void cordic_rotate(input longint x0, input longint y0,
                                          input longint p0,
                                          output longint ox, output longint oy);
        longint x, y, z, dx, dy, p;
        x = x0; y = y0; p = p0 & 64'hFFFF_FFFF;
        if (p >= 64'h4000_0000 && p < 64'hC000_0000) begin
            x = -x; y = -y; p = (p + 64'h8000_0000) & 64'hFFFF_FFFF;
        end
        z = (p >= 64'h8000_0000) ? p - (64'sd1 <<< 32) : p;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr(y, i); dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        ox = unscale(x);
        oy = unscale(y);
    endfunction

    function automatic void cordic_vector(input longint x0, input longint y0,
                                          output longint ang, output longint mag);
        longint x, y, z, dx, dy;
        x = x0; y = y0; z = 0;
        if (x == 0 && y == 0) begin
            ang = 0; mag = 0;
        end else begin
            if (x < 0) begin
                x = -x; y = -y; z = 64'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = asr(y, i); dy = asr(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; z += ATAN_TAB[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_TAB[i];
                end
            end
            ang = z & 64'hFFFF_FFFF;
            mag = unscale(x);
        end
    endfunction

    function automatic logic signed [15:0] to_rpm(longint q8);
        longint r;
        r = asr(q8 * r_gain + 32768, 16);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint lever_term(longint wz, longint arm);
        return (wz * arm * 256) / 1000;
    endfunction

    function automatic logic [12:0] to_count(longint ph);
        longint c;
        c = ((ph & 64'hFFFF_FFFF) * COUNTS_PER_TURN + 64'h8000_0000) >> 32;
        return 13'(c % COUNTS_PER_TURN);
    endfunction

    // Returns the final target phase; flip set when the wrapped error passes a quarter turn.
    function automatic longint aim_wheel(longint az, longint zero, longint pos,
                                         output logic flip);
        longint fin, err;
        fin = (az + phase_of(zero)) & 64'hFFFF_FFFF;
        err = (fin - phase_of(pos)) & 64'hFFFF_FFFF;
        flip = err > 64'h4000_0000 && err < 64'hC000_0000;
        return flip ? fin + 64'h8000_0000 : fin;
    endfunction

    function automatic t_wheels solve_wheels(t_cmd c);
        t_wheels w;
        longint cx, cy, t, laz, raz, lmag, rmag, p, q, fl, fr, unused;
        logic lflip, rflip;
        cordic_rotate(longint'(c.vx) * 256, longint'(c.vy) * 256,
                      phase_of(c.turret), cx, cy);
        t = lever_term(c.wz, r_diag);
        cordic_vector(cy - t, cx - t, laz, lmag);
        cordic_vector(cy + t, cx + t, raz, rmag);
        if (c.vx == 0 && c.vy == 0 && c.wz == 0) begin
            laz = 0; raz = 0;
        end
        w.ltgt = to_count(aim_wheel(laz, r_lzero, c.lpos, lflip));
        w.rtgt = to_count(aim_wheel(raz, r_rzero, c.rpos, rflip));
        p = cx - lever_term(c.wz, r_army);
        q = cy + lever_term(c.wz, r_armx);
        cordic_rotate(p, q, -phase_of(r_fldir), fl, unused);
        cordic_rotate(p, q, -phase_of(r_frdir), fr, unused);
        w.fl = to_rpm(fl);
        w.rl = to_rpm(lflip ? lmag : -lmag);
        w.rr = to_rpm(rflip ? -rmag : rmag);
        w.fr = to_rpm(fr);
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // Driver: config writes on request; one command per transfer, random gap after each
    always @(posedge i_clk) begin
        if (i_cfg_we) i_cfg_we <= 1'b0;
        if (cfg_req && !i_cfg_we) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= cfg_req_idx;
            i_cfg_data <= cfg_req_data;
            cfg_req    <= 1'b0;
        end
        if (start && !busy) begin
            wheels_q.push_back(solve_wheels({i_vel_x, i_vel_y, i_yaw_rate,
                i_turret_angle, i_rear_left_pos, i_rear_right_pos}));
        end
        if (i_rst_n && (!start || !busy)) begin
            if (gap > 0) begin
                gap   <= gap - 1;
                start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                t_cmd c;
                c = cmd_q.pop_front();
                start            <= 1'b1;
                i_vel_x          <= c.vx;
                i_vel_y          <= c.vy;
                i_yaw_rate       <= c.wz;
                i_turret_angle   <= c.turret;
                i_rear_left_pos  <= c.lpos;
                i_rear_right_pos <= c.rpos;
                gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare every result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (wheels_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                t_wheels w;
                w = wheels_q.pop_front();
                if (o_rear_left_target !== w.ltgt)
                    report_mismatch("rear_left_target", o_rear_left_target, w.ltgt);
                if (o_rear_right_target !== w.rtgt)
                    report_mismatch("rear_right_target", o_rear_right_target, w.rtgt);
                if (o_front_left_speed !== w.fl)
                    report_mismatch("front_left_speed", o_front_left_speed, w.fl);
                if (o_rear_left_speed !== w.rl)
                    report_mismatch("rear_left_speed", o_rear_left_speed, w.rl);
                if (o_rear_right_speed !== w.rr)
                    report_mismatch("rear_right_speed", o_rear_right_speed, w.rr);
                if (o_front_right_speed !== w.fr)
                    report_mismatch("front_right_speed", o_front_right_speed, w.fr);
            end
        end
    end

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int mode;
        mode = $urandom_range(0, 9);
        c = CMD_W'({$urandom, $urandom, $urandom});
        if (mode < 4) begin
            // modest speeds, the usual operating range
            c.vx = 16'($urandom_range(0, 8000) - 4000);
            c.vy = 16'($urandom_range(0, 8000) - 4000);
            c.wz = 16'($urandom_range(0, 8000) - 4000);
        end else if (mode == 4) begin
            c.vx = 0; c.vy = 0; c.wz = 0;
        end else if (mode == 5) begin
            c.wz = 0;
        end
        return c;
    endfunction

    task automatic drain();
        while (cmd_q.size() > 0 || start || wheels_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        @(posedge i_clk);
        cfg_req_idx  = idx;
        cfg_req_data = val[15:0];
        cfg_req      = 1'b1;
        while (cfg_req || i_cfg_we) @(posedge i_clk);
        case (idx)
            CFG_DIAG_ARM:        r_diag  = val & 12'hFFF;
            CFG_ARM_X:           r_armx  = val & 12'hFFF;
            CFG_ARM_Y:           r_army  = val & 12'hFFF;
            CFG_FRONT_LEFT_DIR:  r_fldir = val & 13'h1FFF;
            CFG_FRONT_RIGHT_DIR: r_frdir = val & 13'h1FFF;
            CFG_REAR_LEFT_ZERO:  r_lzero = val & 13'h1FFF;
            CFG_REAR_RIGHT_ZERO: r_rzero = val & 13'h1FFF;
            default:             r_gain  = val & 16'hFFFF;
        endcase
    endtask

    task automatic program_all(longint d, longint ax, longint ay, longint fl, longint fr,
                               longint lz, longint rz, longint g);
        write_reg(CFG_DIAG_ARM, d);
        write_reg(CFG_ARM_X, ax);
        write_reg(CFG_ARM_Y, ay);
        write_reg(CFG_FRONT_LEFT_DIR, fl);
        write_reg(CFG_FRONT_RIGHT_DIR, fr);
        write_reg(CFG_REAR_LEFT_ZERO, lz);
        write_reg(CFG_REAR_RIGHT_ZERO, rz);
        write_reg(CFG_RPM_GAIN, g);
    endtask

    initial begin
        t_cmd c;
        r_diag = 300; r_armx = 200; r_army = 200; r_fldir = 1024; r_frdir = 7168;
        r_lzero = 0; r_rzero = 0; r_gain = 256;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero command, quarter and half turn errors
        cmd_q.push_back('{0, 0, 0, 0, 0, 0});
        cmd_q.push_back('{0, 0, 0, 0, 4096, 4096});
        cmd_q.push_back('{0, 0, 0, 0, 2048, 6144});
        cmd_q.push_back('{0, 0, 0, 0, 2049, 6143});
        cmd_q.push_back('{32767, 32767, 32767, 8191, 8191, 8191});
        cmd_q.push_back('{-32768, -32768, -32768, 0, 0, 0});
        cmd_q.push_back('{-32768, 32767, 0, 4096, 2048, 6144});
        cmd_q.push_back('{1000, 0, 0, 2048, 0, 4096});
        cmd_q.push_back('{0, 1000, 0, 6144, 4096, 0});
        cmd_q.push_back('{0, 0, 1000, 0, 0, 0});
        cmd_q.push_back('{0, 0, -1000, 1024, 7000, 100});
        cmd_q.push_back('{-1, -1, -1, 8191, 1, 1});
        cmd_q.push_back('{1, 1, 1, 1, 8191, 8191});
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: program_all(300, 200, 200, 1024, 7168, 0, 0, 256);
                1: program_all(0, 0, 0, 0, 0, 0, 0, 0);
                2: program_all(4095, 4095, 4095, 8191, 8191, 8191, 8191, 65535);
                3: program_all(1, 4095, 1, 4096, 2048, 4096, 1, 1);
                default: program_all($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 65535));
            endcase
            for (int n = 0; n < 200; n++) begin
                c = rand_cmd();
                cmd_q.push_back(c);
            end
            drain();
        end

        if (errors == 0) begin
            $display("[steer_omni_chassis_kinematics] OK");
        end else begin
            $display("[steer_omni_chassis_kinematics] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[steer_omni_chassis_kinematics] ERROR");
        $finish;
    end

endmodule
